[rtl/core/pli_pkg.sv]
`timescale 1ns / 1ps

package pli_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_ZERO_WIDTH = 2'd1;
  localparam logic [1:0] STATUS_SATURATED  = 2'd2;

  localparam int MAG_W = 33;
  localparam int RES_W = 35;

  typedef struct packed {
    logic               opcode;
    logic [7:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_x;
  } pli_in_t;

  typedef struct packed {
    logic signed [31:0] interp_y;
    logic [7:0]         segment_low;
    logic [1:0]         status;
  } pli_out_t;

endpackage

[rtl/core/pli_muldiv.sv]
`timescale 1ns / 1ps

module pli_muldiv (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [pli_pkg::MAG_W-1:0]       a,
  input  logic [pli_pkg::MAG_W-1:0]       b,
  input  logic [pli_pkg::MAG_W-1:0]       d,
  output logic                            done,
  output logic [pli_pkg::RES_W-1:0]       mag
);
  import pli_pkg::*;

  localparam int P_W       = 2 * MAG_W;
  localparam int MUL_STEPS = MAG_W;
  localparam int DIV_STEPS = P_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_DIV  = 2'd2;
  localparam logic [1:0] P_FIN  = 2'd3;

  logic [1:0]       phase;
  logic [CNT_W-1:0] cnt;
  logic [P_W-1:0]   prod;
  logic [MAG_W-1:0] a_reg;
  logic [MAG_W-1:0] d_reg;
  logic [MAG_W-1:0] rem;

  logic [MAG_W:0]   opa;
  logic [MAG_W:0]   opb;
  logic             cin;
  logic [MAG_W+1:0] sum;
  logic [MAG_W:0]   trial;
  logic             ge;
  logic             big;
  logic             round_up;

  assign trial = {rem, prod[P_W-1]};

  always_comb begin
    if (phase == P_DIV) begin
      opa = trial;
      opb = ~{1'b0, d_reg};
      cin = 1'b1;
    end else begin
      opa = {1'b0, prod[P_W-1:MAG_W]};
      opb = prod[0] ? {1'b0, a_reg} : '0;
      cin = 1'b0;
    end
  end

  assign sum = {1'b0, opa} + {1'b0, opb} + (MAG_W + 2)'(cin);
  assign ge  = sum[MAG_W+1];

  assign big      = |prod[P_W-1:RES_W-1];
  assign round_up = {rem, 1'b0} >= {1'b0, d_reg};
  assign done     = (phase == P_FIN);

  always_comb begin
    if (big) begin
      mag = RES_W'(1) << (RES_W - 1);
    end else begin
      mag = {1'b0, prod[RES_W-2:0]} + RES_W'(round_up);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      cnt   <= '0;
    end else begin
      case (phase)
        P_IDLE: begin
          if (start) begin
            phase <= P_MUL;
            cnt   <= '0;
          end
        end
        P_MUL: begin
          if (cnt == CNT_W'(MUL_STEPS - 1)) begin
            phase <= P_DIV;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        P_DIV: begin
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            phase <= P_FIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        P_FIN: begin
          phase <= P_IDLE;
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      P_IDLE: begin
        if (start) begin
          prod  <= {{MAG_W{1'b0}}, b};
          a_reg <= a;
          d_reg <= d;
          rem   <= '0;
        end
      end
      P_MUL: begin
        prod <= {sum[MAG_W:0], prod[MAG_W-1:1]};
      end
      P_DIV: begin
        rem  <= ge ? sum[MAG_W-1:0] : trial[MAG_W-1:0];
        prod <= {prod[P_W-2:0], ge};
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> phase == P_IDLE)
    else $error("muldiv started while busy");

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    phase == P_MUL |-> cnt < CNT_W'(MUL_STEPS))
    else $error("multiply step count overrun");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == P_DIV || phase == P_FIN) |-> rem < d_reg)
    else $error("division remainder not below divisor");
`endif

endmodule

[rtl/core/piecewise_linear_interpolator_unit.sv]
`timescale 1ns / 1ps
// Piecewise linear interpolator over a table of Q16.16 points.
// Input channel (in_valid / in_stall / in_data): an item with opcode write
// stores point_x and point_y at point_index and gives no result;
// a query item gives one result item on the output channel.
// Configuration: cfg_write with cfg_data sets point_count (points in use),
// clamped to 2..TABLE_DEPTH; write it only while no query is in flight.
// A query reads a table memory with one registered read port: it tests the
// first segment, then the last, then walks the inner entries from the low end,
// one entry per cycle, until the segment is found; then it runs a shared
// add/subtract unit for 33 multiply steps and 66 restoring divide steps.
// A zero-width segment skips the multiply/divide.
// in_stall stays high until the result is registered, so no new item, write
// or query, is taken while a query is in flight.
// The result waits in an output register; if out_stall holds it, a finished
// query waits for the register to drain before the next item is taken.
// Reset clears the sequencer, the output valid and sets point_count to 2;
// table contents are undefined until written.
module piecewise_linear_interpolator_unit #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pli_pkg::pli_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pli_pkg::pli_out_t  out_data,
  input  logic               cfg_write,
  input  logic [8:0]         cfg_data
);
  import pli_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_P1    = 4'd1;
  localparam logic [3:0] S_P2    = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_F0    = 4'd4;
  localparam logic [3:0] S_F1    = 4'd5;
  localparam logic [3:0] S_F2    = 4'd6;
  localparam logic [3:0] S_CALC  = 4'd7;
  localparam logic [3:0] S_START = 4'd8;
  localparam logic [3:0] S_WAIT  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]         state;
  logic [8:0]         point_count;
  logic [IDX_W-1:0]   n_m2;
  logic [IDX_W-1:0]   kk;
  logic [IDX_W-1:0]   lo;
  logic signed [31:0] qx;
  logic signed [31:0] x0;
  logic signed [31:0] y0;
  logic signed [31:0] x1;
  logic signed [31:0] y1;
  logic signed [32:0] dq;
  logic signed [32:0] dy;
  logic signed [32:0] dx;
  logic               neg;
  pli_out_t           res;

  logic [63:0]        mem [TABLE_DEPTH];
  logic [63:0]        mem_q;
  logic [IDX_W-1:0]   rd_addr;
  logic signed [31:0] mx;
  logic signed [31:0] my;

  logic               in_take;
  logic               out_free;
  logic [31:0]        pc32;
  logic [31:0]        eff;
  logic [MAG_W-1:0]   abs_dq;
  logic [MAG_W-1:0]   abs_dy;
  logic [MAG_W-1:0]   abs_dx;
  logic               md_start;
  logic               md_done;
  logic [RES_W-1:0]   md_mag;
  logic signed [RES_W:0] y_ext;
  logic signed [RES_W:0] y_sum;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign mx       = mem_q[63:32];
  assign my       = mem_q[31:0];

  assign pc32 = 32'(point_count);
  always_comb begin
    if (pc32 < 32'd2) begin
      eff = 32'd2;
    end else if (pc32 > 32'(TABLE_DEPTH)) begin
      eff = 32'(TABLE_DEPTH);
    end else begin
      eff = pc32;
    end
  end

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = IDX_W'(1);
      S_P1:    rd_addr = n_m2;
      S_P2:    rd_addr = IDX_W'(2);
      S_SCAN:  rd_addr = kk + 1'b1;
      S_F0:    rd_addr = lo;
      S_F1:    rd_addr = lo + 1'b1;
      default: rd_addr = lo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_take && in_data.opcode == OP_WRITE &&
        32'(in_data.point_index) < 32'(TABLE_DEPTH)) begin
      mem[IDX_W'(in_data.point_index)] <= {in_data.point_x, in_data.point_y};
    end
    mem_q <= mem[rd_addr];
  end

  assign abs_dq   = dq[32] ? MAG_W'(-dq) : MAG_W'(dq);
  assign abs_dy   = dy[32] ? MAG_W'(-dy) : MAG_W'(dy);
  assign abs_dx   = dx[32] ? MAG_W'(-dx) : MAG_W'(dx);
  assign md_start = (state == S_START) && (dx != '0);

  pli_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .a     (abs_dq),
    .b     (abs_dy),
    .d     (abs_dx),
    .done  (md_done),
    .mag   (md_mag)
  );

  assign y_ext = (RES_W + 1)'(y0);
  assign y_sum = neg ? y_ext - $signed({1'b0, md_mag})
                     : y_ext + $signed({1'b0, md_mag});

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 9'd2;
    end else if (cfg_write) begin
      point_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take && in_data.opcode == OP_QUERY) begin
            state <= S_P1;
          end
        end
        S_P1: begin
          if (qx <= mx) begin
            state <= S_F0;
          end else begin
            state <= S_P2;
          end
        end
        S_P2: begin
          if (qx >= mx || 32'(n_m2) < 32'd2) begin
            state <= S_F0;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (qx <= mx || kk >= n_m2) begin
            state <= S_F0;
          end
        end
        S_F0:    state <= S_F1;
        S_F1:    state <= S_F2;
        S_F2:    state <= S_CALC;
        S_CALC:  state <= S_START;
        S_START: begin
          if (dx == '0) begin
            state <= S_OUT;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (md_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        qx   <= in_data.query_x;
        n_m2 <= IDX_W'(eff - 32'd2);
      end
      S_P1: begin
        if (qx <= mx) begin
          lo <= '0;
        end
      end
      S_P2: begin
        if (qx >= mx || 32'(n_m2) < 32'd2) begin
          lo <= n_m2;
        end
        kk <= IDX_W'(2);
      end
      S_SCAN: begin
        if (qx <= mx) begin
          lo <= kk - 1'b1;
        end else if (kk >= n_m2) begin
          lo <= n_m2;
        end
        kk <= kk + 1'b1;
      end
      S_F1: begin
        x0 <= mx;
        y0 <= my;
      end
      S_F2: begin
        x1 <= mx;
        y1 <= my;
      end
      S_CALC: begin
        dq <= 33'(qx) - 33'(x0);
        dy <= 33'(y1) - 33'(y0);
        dx <= 33'(x1) - 33'(x0);
      end
      S_START: begin
        neg             <= dq[32] ^ dy[32] ^ dx[32];
        res.segment_low <= 8'(lo);
        if (dx == '0) begin
          res.interp_y <= y0;
          res.status   <= STATUS_ZERO_WIDTH;
        end
      end
      S_WAIT: begin
        if (md_done) begin
          if (y_sum > (RES_W + 1)'(32'sh7fff_ffff)) begin
            res.interp_y <= 32'sh7fff_ffff;
            res.status   <= STATUS_SATURATED;
          end else if (y_sum < -(RES_W + 1)'(33'sh0_8000_0000)) begin
            res.interp_y <= 32'sh8000_0000;
            res.status   <= STATUS_SATURATED;
          end else begin
            res.interp_y <= 32'(y_sum);
            res.status   <= STATUS_OK;
          end
        end
      end
      default: begin
        lo <= lo;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_data <= res;
    end
  end

`ifndef SYNTH
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> kk <= n_m2)
    else $error("table scan ran past the last segment");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    md_done |-> state == S_WAIT)
    else $error("muldiv finished outside the wait state");

  a_write_no_busy: assert property (@(posedge clk) disable iff (rst)
    (in_take && in_data.opcode == OP_WRITE) |=> state == S_IDLE)
    else $error("write item left the sequencer busy");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == STATUS_SATURATED) |->
      (out_data.interp_y == 32'sh7fff_ffff || out_data.interp_y == 32'sh8000_0000))
    else $error("saturated item without a clamped value");
`endif

endmodule
